### hdl/ipd_frame_header_parser_top_assert.svh
// Assertion macros for the frame header parser.
// IPD_ASSERT checks a property while reset is not asserted; IPD_ASSERT_ALWAYS checks it at every edge.
`ifndef IPD_FRAME_HEADER_PARSER_TOP_ASSERT_SVH
`define IPD_FRAME_HEADER_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define IPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define IPD_ASSERT(lbl, clk, rst_n, prop)
`define IPD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/ipd_pkg.sv
`timescale 1ns / 1ps
package ipd_pkg;

  localparam int unsigned ID_FIELD_CHARS_DEF  = 6;
  localparam int unsigned LEN_FIELD_CHARS_DEF = 21;

  localparam int unsigned LEN_BITS = 16;
  localparam int unsigned DIGIT_W  = LEN_BITS + 1;
  localparam int unsigned PROD_W   = DIGIT_W + 4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] CONN_ID_RESET  = 8'd4;
  localparam logic [15:0] MSG_SIZE_RESET = 16'd2048;

  typedef enum logic [0:0] {
    CFG_MAX_CONN_ID  = 1'b0,
    CFG_MAX_MSG_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_ID      = 3'd0,
    PH_ID_DATA = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4,
    PH_DEAD    = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_ID_LONG      = 4'd1,
    ERR_ID_NOT_DIGIT = 4'd2,
    ERR_ID_OVERSIZED = 4'd3,
    ERR_DATA_ID_LONG = 4'd4,
    ERR_LEN_LONG     = 4'd5,
    ERR_MSG_LONG     = 4'd6,
    ERR_LEN_ZERO     = 4'd7,
    ERR_AFTER_ERROR  = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0]  max_conn_id;
    logic [15:0] max_msg_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_last;
    logic        frame_done;
    logic [7:0]  conn_id;
    logic        data_mode;
    logic [15:0] frame_len;
    err_e        error_code;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### hdl/ipd_parser.sv
`timescale 1ns / 1ps
`include "ipd_frame_header_parser_top_assert.svh"
module ipd_hdr_core
  import ipd_pkg::*;
#(
  parameter int unsigned ID_FIELD_CHARS  = ID_FIELD_CHARS_DEF,
  parameter int unsigned LEN_FIELD_CHARS = LEN_FIELD_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       cmd_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam int unsigned MAX_CHARS =
    (ID_FIELD_CHARS > LEN_FIELD_CHARS) ? ID_FIELD_CHARS : LEN_FIELD_CHARS;
  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);
  localparam logic [CNT_W-1:0] ID_LIMIT  = CNT_W'(ID_FIELD_CHARS);
  localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(LEN_FIELD_CHARS);
  localparam logic [DIGIT_W-1:0] DIGIT_CAP = {DIGIT_W{1'b1}};

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]         first_q, first_d;
  logic [DIGIT_W-1:0] dv_q, dv_d;
  logic               ended_q, ended_d;
  logic [7:0]         id_q, id_d;
  logic               flag_q, flag_d;
  logic [15:0]        len_q, len_d;
  logic [15:0]        seen_q, seen_d;
  err_e               err_q, err_d;

  // field accumulator for a pushed character
  logic [CNT_W-1:0]   push_cnt;
  logic [7:0]         push_first;
  logic [DIGIT_W-1:0] push_dv;
  logic               push_ended;
  logic [PROD_W-1:0]  prod;
  logic [7:0]         id_sat;
  logic [15:0]        len_sat;
  logic               id_big;
  logic [15:0]        seen_inc;
  logic               valid, last;

  always_comb begin
    prod = {1'b0, dv_q, 3'b000} + {3'b000, dv_q, 1'b0}
           + PROD_W'(byte_i - CH_ZERO);
    push_first = (cnt_q == '0) ? byte_i : first_q;
    push_cnt   = cnt_q + CNT_W'(1);
    push_dv    = dv_q;
    push_ended = ended_q;
    if (!ended_q && is_digit(byte_i)) begin
      push_dv = (prod > PROD_W'(DIGIT_CAP)) ? DIGIT_CAP : prod[DIGIT_W-1:0];
    end else begin
      push_ended = 1'b1;
    end
    id_sat  = (dv_q > DIGIT_W'(8'hFF)) ? 8'hFF : dv_q[7:0];
    len_sat = (dv_q > DIGIT_W'(16'hFFFF)) ? 16'hFFFF : dv_q[15:0];
    id_big  = dv_q > DIGIT_W'(cfg_i.max_conn_id);
    seen_inc = seen_q + 16'd1;
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    dv_d    = dv_q;
    ended_d = ended_q;
    id_d    = id_q;
    flag_d  = flag_q;
    len_d   = len_q;
    seen_d  = seen_q;
    err_d   = err_q;
    valid   = 1'b0;
    last    = 1'b0;

    if (step_i) begin
      if (cmd_i) begin
        phase_d = PH_ID;
        cnt_d   = '0;
        first_d = '0;
        dv_d    = '0;
        ended_d = 1'b0;
        id_d    = '0;
        flag_d  = 1'b0;
        len_d   = '0;
        seen_d  = '0;
        err_d   = ERR_NONE;
      end else begin
        unique case (phase_q)
          PH_ID, PH_ID_DATA: begin
            if (cnt_q >= ID_LIMIT) begin
              phase_d = PH_DEAD;
              err_d   = (phase_q == PH_ID) ? ERR_ID_LONG : ERR_DATA_ID_LONG;
            end else if (byte_i == CH_COMMA) begin
              if (phase_q == PH_ID && first_q == CH_D) begin
                phase_d = PH_ID_DATA;
                cnt_d = '0; first_d = '0; dv_d = '0; ended_d = 1'b0;
              end else if (phase_q == PH_ID && !is_digit(first_q)) begin
                phase_d = PH_DEAD;
                err_d   = ERR_ID_NOT_DIGIT;
              end else begin
                id_d = id_sat;
                if (id_big) begin
                  phase_d = PH_DEAD;
                  err_d   = ERR_ID_OVERSIZED;
                end else begin
                  if (phase_q == PH_ID_DATA) flag_d = 1'b1;
                  phase_d = PH_LEN;
                  cnt_d = '0; first_d = '0; dv_d = '0; ended_d = 1'b0;
                end
              end
            end else begin
              cnt_d = push_cnt; first_d = push_first; dv_d = push_dv; ended_d = push_ended;
            end
          end
          PH_LEN: begin
            if (cnt_q >= LEN_LIMIT) begin
              phase_d = PH_DEAD;
              err_d   = ERR_LEN_LONG;
            end else if (byte_i == CH_COLON) begin
              len_d = len_sat;
              if (dv_q >= DIGIT_W'(cfg_i.max_msg_size)) begin
                phase_d = PH_DEAD;
                err_d   = ERR_MSG_LONG;
              end else if (dv_q == '0) begin
                phase_d = PH_DEAD;
                err_d   = ERR_LEN_ZERO;
              end else begin
                phase_d = PH_PAYLOAD;
                seen_d  = '0;
                cnt_d = '0; first_d = '0; dv_d = '0; ended_d = 1'b0;
              end
            end else begin
              cnt_d = push_cnt; first_d = push_first; dv_d = push_dv; ended_d = push_ended;
            end
          end
          PH_PAYLOAD: begin
            valid  = 1'b1;
            seen_d = seen_inc;
            if (seen_inc == len_q) begin
              last    = 1'b1;
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_o.payload_byte  = valid ? byte_i : 8'h00;
    res_o.payload_valid = valid;
    res_o.payload_last  = last;
    res_o.frame_done    = (phase_d == PH_DONE);
    res_o.conn_id       = id_d;
    res_o.data_mode     = flag_d;
    res_o.frame_len     = len_d;
    res_o.error_code    = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      cnt_q   <= '0;
      first_q <= '0;
      dv_q    <= '0;
      ended_q <= 1'b0;
      id_q    <= '0;
      flag_q  <= 1'b0;
      len_q   <= '0;
      seen_q  <= '0;
      err_q   <= ERR_NONE;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      dv_q    <= dv_d;
      ended_q <= ended_d;
      id_q    <= id_d;
      flag_q  <= flag_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      err_q   <= err_d;
    end
  end

  `IPD_ASSERT(a_dead_has_error, clk_i, rst_ni, (phase_q == PH_DEAD) |-> (err_q != ERR_NONE))
  `IPD_ASSERT(a_live_no_error, clk_i, rst_ni, (phase_q != PH_DEAD) |-> (err_q == ERR_NONE))
  `IPD_ASSERT(a_payload_len_set, clk_i, rst_ni, (phase_q == PH_PAYLOAD) |-> (len_q != 16'd0))

endmodule

### hdl/ipd_frame_header_parser_top.sv
`timescale 1ns / 1ps
// Frame header parser: takes one byte per word of the input stream and returns one
// result word per input word, showing the parser state after that byte. The header
// "<id>,<length>:" or "D,<id>,<length>:" is checked against the two limit registers,
// payload bytes are passed through with tlast on the final one, and the first error
// stays latched until a restart word (tuser high). The parser state updates at
// acceptance and the result goes to an output register, so a new word is taken
// every cycle as long as the result side keeps up. Write the limit registers only
// while the stream is idle.
`include "ipd_frame_header_parser_top_assert.svh"
module ipd_frame_header_parser_top
  import ipd_pkg::*;
#(
  parameter int unsigned ID_FIELD_CHARS  = ID_FIELD_CHARS_DEF,
  parameter int unsigned LEN_FIELD_CHARS = LEN_FIELD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] frame_done, [16:9] conn_id, [17] data_mode,
  // [33:18] frame_len, [37:34] error_code, [39:38] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] payload_valid
  output logic        m_axis_tlast,   // payload_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic in_fire;
  logic out_last, out_pay, out_done, out_clean;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_conn_id  <= CONN_ID_RESET;
      cfg_q.max_msg_size <= MSG_SIZE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_CONN_ID:  cfg_q.max_conn_id  <= cfg_data_i[7:0];
        CFG_MAX_MSG_SIZE: cfg_q.max_msg_size <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ipd_hdr_core #(
    .ID_FIELD_CHARS  (ID_FIELD_CHARS),
    .LEN_FIELD_CHARS (LEN_FIELD_CHARS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .cmd_i  (s_axis_tuser),
    .byte_i (s_axis_tdata),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.payload_valid;
  assign m_axis_tlast  = res_q.payload_last;
  assign m_axis_tdata  = {2'b00, res_q.error_code, res_q.frame_len, res_q.data_mode,
                          res_q.conn_id, res_q.frame_done, res_q.payload_byte};

  assign out_last  = out_valid_q && res_q.payload_last;
  assign out_pay   = out_valid_q && res_q.payload_valid;
  assign out_done  = out_valid_q && res_q.frame_done;
  assign out_clean = (res_q.error_code == ERR_NONE);

  `IPD_ASSERT(a_last_is_payload, clk_i, rst_ni, out_last |-> (out_pay && out_done))
  `IPD_ASSERT(a_payload_no_error, clk_i, rst_ni, out_pay |-> out_clean)
  `IPD_ASSERT(a_done_no_error, clk_i, rst_ni, out_done |-> out_clean)

endmodule
